// ===== rtl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude filter.
// ----------------------------------------------------------------------------
package sem_pkg;

   // Line buffer depth and derived widths
   localparam int MAX_WIDTH = 64;
   localparam int COL_W     = $clog2(MAX_WIDTH);

   // Fixed field widths
   localparam int PIXEL_W  = 8;
   localparam int WIDTH_W  = 7;
   localparam int HEIGHT_W = 8;
   localparam int MAG_W    = 8;
   localparam int CSR_W    = 8;

   // Reset and clamp values of the image geometry
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(16);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(16);
   localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [COL_W-1:0]   col_type;
   typedef logic [HEIGHT_W-1:0] row_type;

   // Register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Position of one pixel and what it produces
   typedef struct packed {
      col_type col;
      logic    produce;
      logic    frame_last;
      row_type center_row;
      col_type center_col;
   } scan_info_type;

endpackage

// ===== rtl/sem_req_if.sv =====
// ----------------------------------------------------------------------------
// sem_req_if
// Pixel input channel: valid/ready handshake with one grayscale pixel.
// ----------------------------------------------------------------------------
interface sem_req_if import sem_pkg::*; ();

   logic      valid;
   logic      ready;
   pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);

endinterface

// ===== rtl/sem_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sem_rsp_if
// Result channel: valid/ready handshake with edge magnitude and position.
// ----------------------------------------------------------------------------
interface sem_rsp_if import sem_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   row_type          center_row;
   col_type          center_col;
   logic             frame_last;

   modport source (output valid, output magnitude, output center_row,
                   output center_col, output frame_last, input ready);
   modport sink   (input valid, input magnitude, input center_row,
                   input center_col, input frame_last, output ready);

endinterface

// ===== rtl/sem_line_buffer.sv =====
// ----------------------------------------------------------------------------
// sem_line_buffer
// Two image rows in one memory: each entry holds the older and the newer
// row pixel of a column. Registered read, one write port.
// ----------------------------------------------------------------------------
module sem_line_buffer import sem_pkg::*; (
   input  logic      clock,
   input  logic      rd_en,
   input  col_type   rd_addr,
   output pixel_type rd_top,
   output pixel_type rd_mid,
   input  logic      wr_en,
   input  col_type   wr_addr,
   input  pixel_type wr_mid,
   input  pixel_type wr_bot
);

   logic [2*PIXEL_W-1:0] mem [MAX_WIDTH];
   logic [2*PIXEL_W-1:0] rd_data_ff;

   // Shift the column down one row: middle becomes top, new pixel becomes middle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_mid, wr_bot};
      end
   end

   // Fetch the two upper rows for the incoming pixel
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_top = rd_data_ff[2*PIXEL_W-1:PIXEL_W];
   assign rd_mid = rd_data_ff[PIXEL_W-1:0];

endmodule

// ===== rtl/sem_scan_counter.sv =====
// ----------------------------------------------------------------------------
// sem_scan_counter
// Image geometry registers and the raster position of the next pixel.
// Tells for each pixel whether it closes an interior 3x3 window.
// ----------------------------------------------------------------------------
module sem_scan_counter import sem_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  csr_index_type      csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  logic               advance,
   output scan_info_type      info
);

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   col_type             col_ff;
   col_type             col_in;
   row_type             row_ff;
   row_type             row_in;
   logic [WIDTH_W-1:0]  width_eff;
   logic [HEIGHT_W-1:0] height_eff;
   logic [WIDTH_W-1:0]  col_ext;
   logic [WIDTH_W-1:0]  col_next;
   logic [HEIGHT_W:0]   row_next;

   // Write the geometry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   // Clamp the geometry to what the line buffers support
   always_comb begin
      if (width_ff < WIDTH_MIN) begin
         width_eff = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = width_ff;
      end
      height_eff = (height_ff < HEIGHT_MIN) ? HEIGHT_MIN : height_ff;
   end

   // Advance the raster position, wrap at row and frame end
   always_comb begin
      col_ext  = WIDTH_W'(col_ff);
      col_next = col_ext + WIDTH_W'(1);
      row_next = (HEIGHT_W+1)'(row_ff) + (HEIGHT_W+1)'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (advance) begin
         if (col_next >= width_eff) begin
            col_in = '0;
            row_in = (row_next >= (HEIGHT_W+1)'(height_eff)) ? '0 : row_next[HEIGHT_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Describe the pixel at the current position
   always_comb begin
      info.col        = col_ff;
      info.produce    = (col_ff >= COL_W'(2)) && (col_ext < width_eff) &&
                        (row_ff >= HEIGHT_W'(2)) && (row_ff < height_eff);
      info.frame_last = (row_ff == height_eff - HEIGHT_W'(1)) &&
                        (col_ext == width_eff - WIDTH_W'(1));
      info.center_row = row_ff - HEIGHT_W'(1);
      info.center_col = col_ff - COL_W'(1);
   end

endmodule

// ===== rtl/sem_window.sv =====
// ----------------------------------------------------------------------------
// sem_window
// 3x3 pixel window: two held columns plus the current column, and the
// L1 Sobel magnitude of the window.
// ----------------------------------------------------------------------------
module sem_window import sem_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  pixel_type        top,
   input  pixel_type        mid,
   input  pixel_type        bot,
   output logic [MAG_W-1:0] magnitude
);

   localparam int GRAD_W = PIXEL_W + 4;

   // Entries 0..2: column two back; 3..5: previous column (top, mid, bottom)
   pixel_type win_ff [6];

   logic signed [GRAD_W-1:0] gx;
   logic signed [GRAD_W-1:0] gy;
   logic        [GRAD_W-1:0] abs_gx;
   logic        [GRAD_W-1:0] abs_gy;
   logic        [GRAD_W-1:0] sum;

   function automatic logic signed [GRAD_W-1:0] ext(input pixel_type p);
      return $signed({4'b0000, p});
   endfunction

   // Shift the window by one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= bot;
      end
   end

   // Horizontal and vertical gradients, then |Gx|+|Gy| scaled by 1/8
   always_comb begin
      gx = ext(top) + (ext(mid) <<< 1) + ext(bot)
         - ext(win_ff[0]) - (ext(win_ff[1]) <<< 1) - ext(win_ff[2]);
      gy = ext(win_ff[0]) + (ext(win_ff[3]) <<< 1) + ext(top)
         - ext(win_ff[2]) - (ext(win_ff[5]) <<< 1) - ext(bot);
      abs_gx    = gx[GRAD_W-1] ? 12'(-gx) : 12'(gx);
      abs_gy    = gy[GRAD_W-1] ? 12'(-gy) : 12'(gy);
      sum       = abs_gx + abs_gy;
      magnitude = sum[MAG_W+2:3];
   end

endmodule

// ===== rtl/sobel_edge_magnitude_filter.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_filter
// Streaming 3x3 Sobel edge detector with L1 magnitude over a raster image.
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------
//   req_ch  | in        | pixel
//   rsp_ch  | out       | magnitude, center_row, center_col, frame_last
//   csr_*   | in        | csr_index selects image_width / image_height
//
// One pixel per clock unless a stalled result holds the pipeline; an interior
// pixel's result passes the registered line buffer read and then the result
// register. Border pixels give no result. Synchronous reset clears the
// counters, window and pipeline; line buffer contents stay undefined.
// A stalled result holds the pipeline: req_ch.ready drops only while the
// result register is full, not taken, and the pixel held in the window
// stage has a result.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_filter import sem_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   sem_req_if.sink            req_ch,
   sem_rsp_if.source          rsp_ch,
   input  logic               csr_wr_en,
   input  csr_index_type      csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic             accept;
   logic             s1_advance;
   scan_info_type    scan_info;
   logic             s1_valid_ff;
   pixel_type        s1_pixel_ff;
   scan_info_type    s1_info_ff;
   pixel_type        lb_top;
   pixel_type        lb_mid;
   logic [MAG_W-1:0] win_mag;
   logic             out_valid_ff;
   logic [MAG_W-1:0] out_mag_ff;
   row_type          out_row_ff;
   col_type          out_col_ff;
   logic             out_last_ff;

   // Handshake: the window stage moves on unless its result finds the output full
   assign s1_advance   = s1_valid_ff &&
                         (!s1_info_ff.produce || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign accept       = req_ch.valid && req_ch.ready;

   sem_scan_counter u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .info      (scan_info)
   );

   sem_line_buffer u_lines (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (scan_info.col),
      .rd_top  (lb_top),
      .rd_mid  (lb_mid),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_info_ff.col),
      .wr_mid  (lb_mid),
      .wr_bot  (s1_pixel_ff)
   );

   // Hold the accepted pixel and its position while the rows are fetched
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_ch.pixel;
         s1_info_ff  <= scan_info;
      end
   end

   sem_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_advance),
      .top       (lb_top),
      .mid       (lb_mid),
      .bot       (s1_pixel_ff),
      .magnitude (win_mag)
   );

   // Result register: load on an interior pixel, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance && s1_info_ff.produce) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_info_ff.produce) begin
         out_mag_ff  <= win_mag;
         out_row_ff  <= s1_info_ff.center_row;
         out_col_ff  <= s1_info_ff.center_col;
         out_last_ff <= s1_info_ff.frame_last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.magnitude  = out_mag_ff;
   assign rsp_ch.center_row = out_row_ff;
   assign rsp_ch.center_col = out_col_ff;
   assign rsp_ch.frame_last = out_last_ff;

`ifndef SYNTHESIS
   // Reset empties both pipeline stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");

   // Results only come from interior pixels
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.center_row != '0 && rsp_ch.center_col != '0))
      else $error("result for a border pixel");

   // An empty result register never blocks the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ch.ready)
      else $error("input stalled with empty result register");

   // The line buffer never writes the column it is reading
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff) |-> (scan_info.col != s1_info_ff.col))
      else $error("line buffer read and write hit the same column");

   // A result is loaded only as the window stage moves on
   a_load_on_advance: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(out_valid_ff)) |-> $past(s1_advance))
      else $error("result register loaded without an advance");
`endif

endmodule

// ===== tb/sobel_edge_magnitude_filter_tb.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_filter_tb
// Self-checking bench for the streaming Sobel edge magnitude filter. Pixels
// are pushed in raster order with random gaps while the result side stalls
// at random. A cycle-free predictor keeps its own line buffers, window and
// scan counters and queues the expected magnitude, position and frame-end
// flag of every interior pixel. Results are checked in order. The run covers
// reset geometry, hand-made gradient frames, clamped sizes, a full-height
// frame, geometry changes inside a frame, and long random streams.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sem_pkg::*;

   localparam int TIMEOUT_NS   = 1_000_000;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int PIPE_SETTLE  = 4;

   typedef enum int {
      PIX_UNIFORM,
      PIX_BINARY,
      PIX_BANDED
   } pixel_style_type;

   typedef struct {
      logic [MAG_W-1:0] magnitude;
      row_type          center_row;
      col_type          center_col;
      logic             frame_last;
   } edge_result_type;

   // Three 3x3 frames: both gradients large and positive, opposite signs, flat
   localparam pixel_type GRADIENT_FRAMES [27] = '{
      8'hFF, 8'hFF, 8'hFF,  8'h00, 8'h00, 8'hFF,  8'h00, 8'h00, 8'hFF,
      8'h00, 8'h00, 8'h00,  8'h00, 8'h00, 8'hFF,  8'h00, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF,  8'hFF, 8'hFF, 8'hFF,  8'hFF, 8'hFF, 8'hFF
   };

   logic clock;
   logic reset;
   logic                csr_wr_en;
   csr_index_type       csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   sem_req_if req_ch ();
   sem_rsp_if rsp_ch ();

   sobel_edge_magnitude_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state
   pixel_type           older_row [MAX_WIDTH];
   pixel_type           newer_row [MAX_WIDTH];
   pixel_type           win_regs [6];
   int unsigned         scan_col;
   int unsigned         scan_row;
   logic [WIDTH_W-1:0]  geom_width;
   logic [HEIGHT_W-1:0] geom_height;
   edge_result_type     expected_edges [$];

   // Run control and tallies
   int              req_gap_max;
   int              rsp_gap_max;
   pixel_style_type pixel_style;
   int              pixels_sent;
   int              results_checked;
   int              frame_ends_seen;
   int              geometry_writes;
   int              mismatch_count;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout with %0d results outstanding", $time, expected_edges.size());
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int unsigned eff_width_of(logic [WIDTH_W-1:0] v);
      if (v < WIDTH_MIN) return WIDTH_MIN;
      if (v > WIDTH_MAX) return WIDTH_MAX;
      return v;
   endfunction

   function automatic int unsigned eff_height_of(logic [HEIGHT_W-1:0] v);
      if (v < HEIGHT_MIN) return HEIGHT_MIN;
      return v;
   endfunction

   // Advance the scan by one pixel and queue the edge result it produces
   function automatic void predict_edge(pixel_type px);
      int unsigned     w;
      int unsigned     h;
      int unsigned     c;
      int unsigned     r;
      int unsigned     idx;
      int              gx;
      int              gy;
      int              sum;
      pixel_type       top;
      pixel_type       mid;
      edge_result_type res;
      w   = eff_width_of(geom_width);
      h   = eff_height_of(geom_height);
      c   = scan_col;
      r   = scan_row;
      idx = (c < MAX_WIDTH) ? c : 0;
      top = older_row[idx];
      mid = newer_row[idx];
      older_row[idx] = mid;
      newer_row[idx] = px;

      if (c >= 2 && c < w && r >= 2 && r < h) begin
         gx = int'(top) + 2 * int'(mid) + int'(px)
            - (int'(win_regs[0]) + 2 * int'(win_regs[1]) + int'(win_regs[2]));
         gy = int'(win_regs[0]) + 2 * int'(win_regs[3]) + int'(top)
            - (int'(win_regs[2]) + 2 * int'(win_regs[5]) + int'(px));
         sum = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
         res.magnitude  = MAG_W'(sum >> 3);
         res.center_row = row_type'(r - 1);
         res.center_col = col_type'(c - 1);
         res.frame_last = (r == h - 1) && (c == w - 1);
         expected_edges.push_back(res);
      end

      // Shift the window left by one column
      win_regs[0] = win_regs[3];
      win_regs[1] = win_regs[4];
      win_regs[2] = win_regs[5];
      win_regs[3] = top;
      win_regs[4] = mid;
      win_regs[5] = px;

      // Wrap the counters at row and frame end
      if (c + 1 >= w) begin
         scan_col = 0;
         scan_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         scan_col = c + 1;
      end
   endfunction

   function automatic pixel_type draw_pixel(pixel_style_type style);
      case (style)
         PIX_BINARY: begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         PIX_BANDED: begin
            return $urandom_range(0, 1) ? pixel_type'($urandom_range(240, 255))
                                        : pixel_type'($urandom_range(0, 15));
         end
         default: begin
            return pixel_type'($urandom);
         end
      endcase
   endfunction

   function automatic int pick_gap_max();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 2;
         default: return 10;
      endcase
   endfunction

   // Send one pixel transaction after a random gap
   task automatic send_pixel(pixel_type px);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      repeat (gap) @(negedge clock) req_ch.valid <= 1'b0;
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.pixel <= px;
      do @(posedge clock); while (!req_ch.ready);
      predict_edge(px);
      pixels_sent++;
   endtask

   // Send one whole frame at the current geometry, starting at a frame boundary
   task automatic send_frame();
      int unsigned count;
      count = eff_width_of(geom_width) * eff_height_of(geom_height);
      repeat (count) send_pixel(draw_pixel(pixel_style));
   endtask

   // Hold off input until every expected result has arrived, then let the pipe settle
   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock) req_ch.valid <= 1'b0;
      while (expected_edges.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_edges.size() > 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_edges.size());
         mismatch_count += expected_edges.size();
         expected_edges.delete();
      end
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) begin
         geom_width = data[WIDTH_W-1:0];
      end else begin
         geom_height = data[HEIGHT_W-1:0];
      end
   endtask

   // Change both dimensions while idle. A wider row may only start at a frame
   // boundary, otherwise the window would read line buffer columns never filled.
   task automatic set_geometry(logic [CSR_W-1:0] width_val, logic [CSR_W-1:0] height_val);
      if (eff_width_of(width_val[WIDTH_W-1:0]) > eff_width_of(geom_width)) begin
         while (scan_col != 0 || scan_row != 0) send_pixel(draw_pixel(pixel_style));
      end
      drain_results();
      write_csr(CSR_IMAGE_WIDTH, width_val);
      write_csr(CSR_IMAGE_HEIGHT, height_val);
      geometry_writes++;
   endtask

   // Result side: hold ready low for a random stall before each transaction
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (stall > 0) begin
            @(negedge clock) rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Compare each result transaction with the oldest expectation
   task automatic check_edge_result();
      edge_result_type exp_r;
      if (expected_edges.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected result mag %0d row %0d col %0d last %0b", $time,
                  rsp_ch.magnitude, rsp_ch.center_row, rsp_ch.center_col,
                  rsp_ch.frame_last);
      end else begin
         exp_r = expected_edges.pop_front();
         results_checked++;
         if (rsp_ch.frame_last === 1'b1) frame_ends_seen++;
         if (rsp_ch.magnitude !== exp_r.magnitude || rsp_ch.center_row !== exp_r.center_row ||
             rsp_ch.center_col !== exp_r.center_col ||
             rsp_ch.frame_last !== exp_r.frame_last) begin
            mismatch_count++;
            $display("%0t: expected mag/row/col/last %0d %0d %0d %0b, got %0d %0d %0d %0b",
                     $time, exp_r.magnitude, exp_r.center_row, exp_r.center_col,
                     exp_r.frame_last, rsp_ch.magnitude, rsp_ch.center_row,
                     rsp_ch.center_col, rsp_ch.frame_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_edge_result();
   end

   // One frame at the geometry the block comes out of reset with
   task automatic test_reset_geometry();
      req_gap_max = 3;
      rsp_gap_max = 3;
      pixel_style = PIX_UNIFORM;
      send_frame();
   endtask

   // Hand-made 3x3 frames: large gradients of both signs and a flat image
   task automatic test_gradient_frames();
      req_gap_max = 0;
      rsp_gap_max = 0;
      set_geometry(8'd3, 8'd3);
      foreach (GRADIENT_FRAMES[i]) send_pixel(GRADIENT_FRAMES[i]);
   endtask

   // Sizes below the minimum and above the line buffer depth
   task automatic test_clamped_geometry();
      req_gap_max = 10;
      rsp_gap_max = 10;
      pixel_style = PIX_BINARY;
      set_geometry(8'd0, 8'd0);
      send_frame();
      set_geometry(8'd1, 8'd1);
      send_frame();
      set_geometry(8'd2, 8'd2);
      send_frame();
      req_gap_max = 0;
      rsp_gap_max = 2;
      pixel_style = PIX_BANDED;
      // upper bit of the data is outside the width register
      set_geometry(8'hC3, 8'd3);
      send_frame();
   endtask

   // Narrowest image at full height: last row index and frame end at the top
   task automatic test_tall_frame();
      req_gap_max = 2;
      rsp_gap_max = 0;
      pixel_style = PIX_UNIFORM;
      set_geometry(8'd2, 8'd255);
      send_frame();
   endtask

   // Shrink width and height while counters sit beyond the new limits, then raise the height
   task automatic test_midframe_change();
      req_gap_max = 2;
      rsp_gap_max = 2;
      pixel_style = PIX_UNIFORM;
      set_geometry(8'd20, 8'd10);
      repeat (75) send_pixel(draw_pixel(pixel_style));
      drain_results();
      write_csr(CSR_IMAGE_WIDTH, 8'd8);
      repeat (30) send_pixel(draw_pixel(pixel_style));
      drain_results();
      write_csr(CSR_IMAGE_HEIGHT, 8'd3);
      repeat (40) send_pixel(draw_pixel(pixel_style));
      drain_results();
      write_csr(CSR_IMAGE_HEIGHT, 8'd12);
      repeat (50) send_pixel(draw_pixel(pixel_style));
      geometry_writes += 3;
   endtask

   // Random phases of geometry, idling and image content
   task automatic test_random_stream();
      int          phases;
      int          length;
      logic [7:0]  width_val;
      logic [7:0]  height_val;
      phases = 0;
      while (phases < 3 || pixels_sent < 1600) begin
         case ($urandom_range(0, 9))
            0: width_val = 8'd64;
            1: width_val = 8'($urandom_range(0, 2));
            2: width_val = 8'($urandom_range(65, 255));
            default: width_val = 8'($urandom_range(3, 12));
         endcase
         case ($urandom_range(0, 7))
            0: height_val = 8'($urandom_range(0, 2));
            1: height_val = 8'($urandom_range(13, 24));
            default: height_val = 8'($urandom_range(3, 8));
         endcase
         if ($urandom_range(0, 3) != 0) set_geometry(width_val, height_val);
         else drain_results();
         req_gap_max = pick_gap_max();
         rsp_gap_max = pick_gap_max();
         pixel_style = pixel_style_type'($urandom_range(0, 2));
         length = $urandom_range(20, 80);
         repeat (length) send_pixel(draw_pixel(pixel_style));
         phases++;
      end
   endtask

   // Main sequence
   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_IMAGE_WIDTH;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      foreach (older_row[i]) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      foreach (win_regs[i]) win_regs[i] = '0;
      scan_col        = 0;
      scan_row        = 0;
      geom_width      = WIDTH_RESET;
      geom_height     = HEIGHT_RESET;
      req_gap_max     = 0;
      rsp_gap_max     = 0;
      pixel_style     = PIX_UNIFORM;
      pixels_sent     = 0;
      results_checked = 0;
      frame_ends_seen = 0;
      geometry_writes = 0;
      mismatch_count  = 0;

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_reset_geometry();
      test_gradient_frames();
      test_clamped_geometry();
      test_tall_frame();
      test_midframe_change();
      test_random_stream();
      drain_results();

      $display("Sent %0d pixels, checked %0d edge results with %0d frame ends",
               pixels_sent, results_checked, frame_ends_seen);
      $display("Geometry changes: %0d, incl. clamped sizes, full height and mid-frame shrink",
               geometry_writes);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
